/* sv/itf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package itf_pkg;

  localparam int CORDIC_STEPS_DEF = 16;

  localparam int InW     = 16;
  localparam int CfgW    = 24;
  localparam int CfgIdxW = 2;
  localparam int WgtW    = 17;
  localparam int ScaleW  = 24;
  localparam int GainW   = 8;
  localparam int OutW    = 32;

  localparam int TabIdxW = 5;
  localparam int AngW    = 26;
  localparam int CordW   = 36;
  localparam int MulAW   = 32;
  localparam int MulBW   = 18;
  localparam int ProdW   = 50;
  localparam int SumW    = 52;
  localparam int GzW     = 25;
  localparam int PcW     = 5;

  localparam logic signed [AngW-1:0] DEG180 = AngW'(11796480);

  localparam logic [CfgIdxW-1:0] CFG_ACCEL_WEIGHT = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_GYRO_SCALE   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_YAW_GAIN     = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_YAW_BIAS     = 2'd3;

  typedef enum logic [4:0] {
    UOP_MUL_GY,
    UOP_INT_ROLL,
    UOP_MUL_GX,
    UOP_INT_PITCH,
    UOP_MUL_GZ,
    UOP_SAVE_GZ,
    UOP_MUL_YAW,
    UOP_ACC_YAW,
    UOP_LOAD_ROLL,
    UOP_CORDIC,
    UOP_MUL_WA,
    UOP_MUL_WB_ROLL,
    UOP_FUSE_ROLL,
    UOP_LOAD_PITCH,
    UOP_MUL_WB_PITCH,
    UOP_FUSE_PITCH,
    UOP_EMIT
  } uop_t;

  typedef enum logic [1:0] {
    COND_NEXT,
    COND_CORDIC,
    COND_OUT
  } cond_t;

  typedef struct packed {
    uop_t           op;
    cond_t          cond;
    logic [PcW-1:0] target;
  } ucw_t;

  typedef struct packed {
    logic load;
    logic step;
  } cordic_ctl_t;

  typedef struct packed {
    logic done;
  } cordic_sts_t;

  localparam logic [PcW-1:0] PC_CORD_ROLL  = 5'd9;
  localparam logic [PcW-1:0] PC_CORD_PITCH = 5'd14;
  localparam logic [PcW-1:0] PC_EMIT       = 5'd18;

  function automatic logic signed [AngW-1:0] atan_deg(input logic [TabIdxW-1:0] i);
    logic signed [AngW-1:0] v;
    case (i)
      5'd0:    v = AngW'(2949120);
      5'd1:    v = AngW'(1740967);
      5'd2:    v = AngW'(919879);
      5'd3:    v = AngW'(466945);
      5'd4:    v = AngW'(234379);
      5'd5:    v = AngW'(117304);
      5'd6:    v = AngW'(58666);
      5'd7:    v = AngW'(29335);
      5'd8:    v = AngW'(14668);
      5'd9:    v = AngW'(7334);
      5'd10:   v = AngW'(3667);
      5'd11:   v = AngW'(1833);
      5'd12:   v = AngW'(917);
      5'd13:   v = AngW'(458);
      5'd14:   v = AngW'(229);
      5'd15:   v = AngW'(115);
      5'd16:   v = AngW'(57);
      5'd17:   v = AngW'(29);
      5'd18:   v = AngW'(14);
      5'd19:   v = AngW'(7);
      5'd20:   v = AngW'(4);
      5'd21:   v = AngW'(2);
      5'd22:   v = AngW'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic ucw_t ucode(input logic [PcW-1:0] pc);
    ucw_t w;
    case (pc)
      5'd0:    w = '{UOP_MUL_GY,       COND_NEXT,   '0};
      5'd1:    w = '{UOP_INT_ROLL,     COND_NEXT,   '0};
      5'd2:    w = '{UOP_MUL_GX,       COND_NEXT,   '0};
      5'd3:    w = '{UOP_INT_PITCH,    COND_NEXT,   '0};
      5'd4:    w = '{UOP_MUL_GZ,       COND_NEXT,   '0};
      5'd5:    w = '{UOP_SAVE_GZ,      COND_NEXT,   '0};
      5'd6:    w = '{UOP_MUL_YAW,      COND_NEXT,   '0};
      5'd7:    w = '{UOP_ACC_YAW,      COND_NEXT,   '0};
      5'd8:    w = '{UOP_LOAD_ROLL,    COND_NEXT,   '0};
      5'd9:    w = '{UOP_CORDIC,       COND_CORDIC, PC_CORD_ROLL};
      5'd10:   w = '{UOP_MUL_WA,       COND_NEXT,   '0};
      5'd11:   w = '{UOP_MUL_WB_ROLL,  COND_NEXT,   '0};
      5'd12:   w = '{UOP_FUSE_ROLL,    COND_NEXT,   '0};
      5'd13:   w = '{UOP_LOAD_PITCH,   COND_NEXT,   '0};
      5'd14:   w = '{UOP_CORDIC,       COND_CORDIC, PC_CORD_PITCH};
      5'd15:   w = '{UOP_MUL_WA,       COND_NEXT,   '0};
      5'd16:   w = '{UOP_MUL_WB_PITCH, COND_NEXT,   '0};
      5'd17:   w = '{UOP_FUSE_PITCH,   COND_NEXT,   '0};
      5'd18:   w = '{UOP_EMIT,         COND_OUT,    PC_EMIT};
      default: w = '{UOP_EMIT,         COND_OUT,    PC_EMIT};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

/* sv/imu_tilt_fusion.sv */
// Six-axis tilt estimator with a complementary filter.
// Input channel: in_valid / in_stall with six signed 16-bit raw counts per beat.
// Result channel: out_valid / out_stall with roll, pitch and yaw in signed Q16.16.
// Config port: cfg_wr_en, cfg_index, cfg_wdata; write only while the block is idle.
// A beat is accepted when in_valid is high and in_stall is low. One result beat
// follows each accepted input beat.
// An atan2 with a zero first argument skips its iterations. One control word
// per cycle runs a shared 32x18 multiplier and an iterative CORDIC. in_stall
// stays high while a beat is in work, so a new beat is taken only once the
// last one is through. The result sits in an output register; if it still
// holds a result that out_stall keeps back at the end of the program, the
// last step holds until the register frees.
// Reset (rst_n low at a clock edge) clears the integrals and yaw, drops any
// beat in work and any pending result, and restores the config defaults.
`timescale 1ns / 1ps
`default_nettype none

module imu_tilt_fusion #(
  parameter int CORDIC_STEPS = itf_pkg::CORDIC_STEPS_DEF
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   in_valid,
  output logic                                  in_stall,
  input  wire logic signed [itf_pkg::InW-1:0]   in_accel_x,
  input  wire logic signed [itf_pkg::InW-1:0]   in_accel_y,
  input  wire logic signed [itf_pkg::InW-1:0]   in_accel_z,
  input  wire logic signed [itf_pkg::InW-1:0]   in_gyro_x,
  input  wire logic signed [itf_pkg::InW-1:0]   in_gyro_y,
  input  wire logic signed [itf_pkg::InW-1:0]   in_gyro_z,
  output logic                                  out_valid,
  input  wire                                   out_stall,
  output logic signed [itf_pkg::OutW-1:0]       out_roll_angle,
  output logic signed [itf_pkg::OutW-1:0]       out_pitch_angle,
  output logic signed [itf_pkg::OutW-1:0]       out_yaw_angle,
  input  wire                                   cfg_wr_en,
  input  wire logic [itf_pkg::CfgIdxW-1:0]      cfg_index,
  input  wire logic [itf_pkg::CfgW-1:0]         cfg_wdata
);

  localparam int InW   = itf_pkg::InW;
  localparam int OutW  = itf_pkg::OutW;
  localparam int SumW  = itf_pkg::SumW;
  localparam int ProdW = itf_pkg::ProdW;
  localparam int MulAW = itf_pkg::MulAW;
  localparam int MulBW = itf_pkg::MulBW;
  localparam int GzW   = itf_pkg::GzW;
  localparam int PcW   = itf_pkg::PcW;

  localparam logic signed [SumW-1:0] SatMax = SumW'(2147483647);
  localparam logic signed [SumW-1:0] SatMin = -SatMax - SumW'(1);

  function automatic logic signed [SumW-17:0] rnd16(input logic signed [SumW-1:0] v);
    logic signed [SumW-1:0] t;
    t = v + SumW'(32768);
    return t[SumW-1:16];
  endfunction

  function automatic logic signed [OutW-1:0] sat32(input logic signed [SumW-1:0] v);
    logic signed [OutW-1:0] r;
    if (v > SatMax) begin
      r = SatMax[OutW-1:0];
    end else if (v < SatMin) begin
      r = SatMin[OutW-1:0];
    end else begin
      r = v[OutW-1:0];
    end
    return r;
  endfunction

  // config
  logic [itf_pkg::WgtW-1:0]   accel_weight_r;
  logic [itf_pkg::ScaleW-1:0] gyro_scale_r;
  logic [itf_pkg::GainW-1:0]  yaw_gain_r;
  logic signed [InW-1:0]      yaw_bias_r;

  // control
  logic [PcW-1:0] pc_r, pc_nxt;
  logic           busy_r, busy_nxt;
  logic           out_valid_r, out_valid_nxt;
  itf_pkg::ucw_t  ucw;
  logic           in_acc, out_full, emit_go;

  // state and datapath
  logic signed [OutW-1:0]  roll_int_r, pitch_int_r, yaw_r;
  logic signed [OutW-1:0]  roll_res_r, pitch_res_r;
  logic signed [OutW-1:0]  out_roll_r, out_pitch_r, out_yaw_r;
  logic signed [InW-1:0]   ax_r, ay_r, az_r, gx_r, gy_r, gz_raw_r;
  logic signed [GzW-1:0]   gz_r;
  logic signed [ProdW-1:0] prod_r, acc_r, prod_nxt;
  logic signed [MulAW-1:0] mul_a;
  logic signed [MulBW-1:0] mul_b, wgt, wgt_c;
  logic signed [OutW-1:0]  fused;

  itf_pkg::cordic_ctl_t         cctl;
  itf_pkg::cordic_sts_t         csts;
  logic signed [InW-1:0]        cy, cx;
  logic signed [itf_pkg::AngW-1:0] cz;

  assign ucw      = itf_pkg::ucode(pc_r);
  assign in_acc   = in_valid && !busy_r;
  assign out_full = out_valid_r && out_stall;
  assign emit_go  = busy_r && (ucw.op == itf_pkg::UOP_EMIT) && !out_full;

  assign in_stall        = busy_r;
  assign out_valid       = out_valid_r;
  assign out_roll_angle  = out_roll_r;
  assign out_pitch_angle = out_pitch_r;
  assign out_yaw_angle   = out_yaw_r;

  // sequencer
  always_comb begin
    pc_nxt   = pc_r;
    busy_nxt = busy_r;
    if (in_acc) begin
      pc_nxt   = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      case (ucw.cond)
        itf_pkg::COND_NEXT: begin
          pc_nxt = pc_r + 1'b1;
        end
        itf_pkg::COND_CORDIC: begin
          pc_nxt = csts.done ? pc_r + 1'b1 : ucw.target;
        end
        itf_pkg::COND_OUT: begin
          if (out_full) begin
            pc_nxt = ucw.target;
          end else begin
            pc_nxt   = '0;
            busy_nxt = 1'b0;
          end
        end
        default: begin
          pc_nxt   = '0;
          busy_nxt = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (emit_go) begin
      out_valid_nxt = 1'b1;
    end
  end

  // shared multiplier operand select
  assign wgt   = $signed(MulBW'(accel_weight_r));
  assign wgt_c = $signed(MulBW'(65536)) - wgt;

  always_comb begin
    case (ucw.op)
      itf_pkg::UOP_MUL_GY: begin
        mul_a = $signed(MulAW'(gyro_scale_r));
        mul_b = MulBW'(gy_r);
      end
      itf_pkg::UOP_MUL_GX: begin
        mul_a = $signed(MulAW'(gyro_scale_r));
        mul_b = MulBW'(gx_r);
      end
      itf_pkg::UOP_MUL_GZ: begin
        mul_a = $signed(MulAW'(gyro_scale_r));
        mul_b = MulBW'(gz_raw_r);
      end
      itf_pkg::UOP_MUL_YAW: begin
        mul_a = MulAW'(gz_r);
        mul_b = $signed(MulBW'(yaw_gain_r));
      end
      itf_pkg::UOP_MUL_WA: begin
        mul_a = MulAW'(cz);
        mul_b = wgt;
      end
      itf_pkg::UOP_MUL_WB_ROLL: begin
        mul_a = roll_int_r;
        mul_b = wgt_c;
      end
      itf_pkg::UOP_MUL_WB_PITCH: begin
        mul_a = pitch_int_r;
        mul_b = wgt_c;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_nxt = ProdW'(mul_a) * ProdW'(mul_b);
  assign fused    = sat32(SumW'(rnd16(SumW'(acc_r) + SumW'(prod_r))));

  // CORDIC control
  assign cctl.load = busy_r && ((ucw.op == itf_pkg::UOP_LOAD_ROLL) ||
                                (ucw.op == itf_pkg::UOP_LOAD_PITCH));
  assign cctl.step = busy_r && (ucw.op == itf_pkg::UOP_CORDIC);
  assign cy        = (ucw.op == itf_pkg::UOP_LOAD_PITCH) ? ax_r : ay_r;
  assign cx        = az_r;

  itf_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (cctl),
    .y_in  (cy),
    .x_in  (cx),
    .sts   (csts),
    .z_out (cz)
  );

  // control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r           <= '0;
      busy_r         <= 1'b0;
      out_valid_r    <= 1'b0;
      accel_weight_r <= itf_pkg::WgtW'(62259);
      gyro_scale_r   <= itf_pkg::ScaleW'(374806);
      yaw_gain_r     <= itf_pkg::GainW'(20);
      yaw_bias_r     <= InW'(1029);
      roll_int_r     <= '0;
      pitch_int_r    <= '0;
      yaw_r          <= '0;
    end else begin
      pc_r        <= pc_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        case (cfg_index)
          itf_pkg::CFG_ACCEL_WEIGHT: accel_weight_r <= cfg_wdata[itf_pkg::WgtW-1:0];
          itf_pkg::CFG_GYRO_SCALE:   gyro_scale_r   <= cfg_wdata[itf_pkg::ScaleW-1:0];
          itf_pkg::CFG_YAW_GAIN:     yaw_gain_r     <= cfg_wdata[itf_pkg::GainW-1:0];
          itf_pkg::CFG_YAW_BIAS:     yaw_bias_r     <= $signed(cfg_wdata[InW-1:0]);
          default: begin
          end
        endcase
      end
      if (busy_r) begin
        case (ucw.op)
          itf_pkg::UOP_INT_ROLL: begin
            roll_int_r <= sat32(SumW'(roll_int_r) + SumW'(rnd16(SumW'(prod_r))));
          end
          itf_pkg::UOP_INT_PITCH: begin
            pitch_int_r <= sat32(SumW'(pitch_int_r) + SumW'(rnd16(SumW'(prod_r))));
          end
          itf_pkg::UOP_ACC_YAW: begin
            yaw_r <= sat32(SumW'(yaw_r) + SumW'(prod_r) + SumW'(yaw_bias_r));
          end
          default: begin
          end
        endcase
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      ax_r     <= in_accel_x;
      ay_r     <= in_accel_y;
      az_r     <= in_accel_z;
      gx_r     <= in_gyro_x;
      gy_r     <= in_gyro_y;
      gz_raw_r <= in_gyro_z;
    end
    if (busy_r) begin
      case (ucw.op)
        itf_pkg::UOP_MUL_GY, itf_pkg::UOP_MUL_GX, itf_pkg::UOP_MUL_GZ,
        itf_pkg::UOP_MUL_YAW, itf_pkg::UOP_MUL_WA: begin
          prod_r <= prod_nxt;
        end
        itf_pkg::UOP_MUL_WB_ROLL, itf_pkg::UOP_MUL_WB_PITCH: begin
          acc_r  <= prod_r;
          prod_r <= prod_nxt;
        end
        itf_pkg::UOP_SAVE_GZ: begin
          gz_r <= GzW'(rnd16(SumW'(prod_r)));
        end
        itf_pkg::UOP_FUSE_ROLL: begin
          roll_res_r <= fused;
        end
        itf_pkg::UOP_FUSE_PITCH: begin
          pitch_res_r <= fused;
        end
        default: begin
        end
      endcase
    end
    if (emit_go) begin
      out_roll_r  <= roll_res_r;
      out_pitch_r <= pitch_res_r;
      out_yaw_r   <= yaw_r;
    end
  end

endmodule

`default_nettype wire

/* sv/itf_cordic.sv */
`timescale 1ns / 1ps
`default_nettype none

module itf_cordic #(
  parameter int STEPS = itf_pkg::CORDIC_STEPS_DEF
) (
  input  wire                                     clk,
  input  wire                                     rst_n,
  input  wire itf_pkg::cordic_ctl_t               ctl,
  input  wire logic signed [itf_pkg::InW-1:0]     y_in,
  input  wire logic signed [itf_pkg::InW-1:0]     x_in,
  output itf_pkg::cordic_sts_t                    sts,
  output logic signed [itf_pkg::AngW-1:0]         z_out
);

  localparam int CntW  = $clog2(STEPS + 1);
  localparam int CordW = itf_pkg::CordW;
  localparam int AngW  = itf_pkg::AngW;

  logic signed [CordW-1:0] x_r, y_r, x_nxt, y_nxt;
  logic signed [AngW-1:0]  z_r, z_nxt;
  logic [CntW-1:0]         cnt_r;
  logic                    skip_r;

  logic signed [itf_pkg::InW:0] xe, ye, xa, ya;
  logic signed [CordW-1:0]      xs, ys;
  logic signed [AngW-1:0]       z_ld, tab;
  logic                         done;

  assign done     = skip_r || (cnt_r == CntW'(STEPS));
  assign sts.done = done;
  assign z_out    = z_r;

  always_comb begin
    xe = (itf_pkg::InW + 1)'(x_in);
    ye = (itf_pkg::InW + 1)'(y_in);
    xa = x_in[itf_pkg::InW-1] ? -xe : xe;
    ya = x_in[itf_pkg::InW-1] ? -ye : ye;
    if (x_in[itf_pkg::InW-1]) begin
      z_ld = y_in[itf_pkg::InW-1] ? -itf_pkg::DEG180 : itf_pkg::DEG180;
    end else begin
      z_ld = '0;
    end
    xs  = x_r >>> cnt_r;
    ys  = y_r >>> cnt_r;
    tab = itf_pkg::atan_deg(itf_pkg::TabIdxW'(cnt_r));
    if (y_r > 0) begin
      x_nxt = x_r + ys;
      y_nxt = y_r - xs;
      z_nxt = z_r + tab;
    end else begin
      x_nxt = x_r - ys;
      y_nxt = y_r + xs;
      z_nxt = z_r - tab;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      skip_r <= 1'b1;
    end else if (ctl.load) begin
      cnt_r  <= '0;
      skip_r <= (y_in == '0);
    end else if (ctl.step && !done) begin
      cnt_r  <= cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      x_r <= CordW'(xa) <<< 16;
      y_r <= CordW'(ya) <<< 16;
      z_r <= z_ld;
    end else if (ctl.step && !done) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

endmodule

`default_nettype wire

/* sv/itf_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module itf_checker (
  input wire                                  clk,
  input wire                                  rst_n,
  input wire                                  in_valid,
  input wire                                  in_stall,
  input wire                                  out_valid,
  input wire                                  out_stall,
  input wire logic [itf_pkg::OutW-1:0]        out_roll_angle,
  input wire logic [itf_pkg::OutW-1:0]        out_pitch_angle,
  input wire logic [itf_pkg::OutW-1:0]        out_yaw_angle
);

  // an accepted beat keeps the input side closed while it is in work
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after accept");

  // a new result shows up only as the block finishes its beat
  a_result_at_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !in_stall)
    else $error("result appeared while beat still in work");

  // finishing a beat always leaves a result behind
  a_finish_has_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_stall) |-> out_valid)
    else $error("beat finished without a result");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_roll_angle) &&
      $stable(out_pitch_angle) && $stable(out_yaw_angle))
    else $error("stalled result beat changed");

endmodule

bind imu_tilt_fusion itf_checker u_itf_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_roll_angle  (out_roll_angle),
  .out_pitch_angle (out_pitch_angle),
  .out_yaw_angle   (out_yaw_angle)
);

`default_nettype wire

/* bench/testbench.sv */
`timescale 1ns / 1ps

module testbench;

  localparam int          CordicSteps = itf_pkg::CORDIC_STEPS_DEF;
  localparam int          DirRows     = 24;
  localparam int unsigned CycleLimit  = 1_000_000;
  localparam longint      HalfTurn    = 64'sd11796480;
  localparam longint      QMax        = 64'sd2147483647;
  localparam longint      QMin        = -64'sd2147483648;

  typedef struct packed {
    logic signed [itf_pkg::InW-1:0] ax, ay, az, gx, gy, gz;
  } imu_sample_t;

  typedef struct packed {
    logic signed [itf_pkg::OutW-1:0] roll, pitch, yaw;
  } attitude_t;

  typedef struct packed {
    int ax, ay, az, gx, gy, gz;
    bit known;
    int roll, pitch, yaw;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic signed [itf_pkg::InW-1:0] in_accel_x, in_accel_y, in_accel_z;
  logic signed [itf_pkg::InW-1:0] in_gyro_x, in_gyro_y, in_gyro_z;
  logic out_valid;
  logic out_stall;
  logic signed [itf_pkg::OutW-1:0] out_roll_angle, out_pitch_angle, out_yaw_angle;
  logic cfg_wr_en;
  logic [itf_pkg::CfgIdxW-1:0] cfg_index;
  logic [itf_pkg::CfgW-1:0] cfg_wdata;

  attitude_t   pending_angles [$];
  attitude_t   head_angles;
  int          mismatches = 0;
  bit          calm = 1'b0;
  int unsigned cycle_count = 0;

  longint weight_r, gyro_scale_r, yaw_gain_r, yaw_bias_r;
  longint roll_sum, pitch_sum, yaw_sum;

  int step_angle [24] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  dir_row_t dir_rows [DirRows] = '{
    '{0, 0, 0, 0, 0, 0, 1'b1, 0, 0, 1029},
    '{0, 0, -100, 0, 0, 0, 1'b1, 11206620, 11206620, 2058},
    '{0, 0, 100, 0, 0, 0, 1'b1, 0, 0, 3087},
    '{32767, 32767, 32767, 0, 0, 0, 1'b0, 0, 0, 0},
    '{-32768, -32768, -32768, 0, 0, 0, 1'b0, 0, 0, 0},
    '{32767, -32768, 0, 0, 0, 0, 1'b0, 0, 0, 0},
    '{-32768, 32767, -1, 0, 0, 0, 1'b0, 0, 0, 0},
    '{1, -1, -32768, 0, 0, 0, 1'b0, 0, 0, 0},
    '{0, -5, -7, 0, 0, 0, 1'b0, 0, 0, 0},
    '{0, 0, 0, 32767, -32768, 32767, 1'b0, 0, 0, 0},
    '{0, 0, 0, -32768, 32767, -32768, 1'b0, 0, 0, 0},
    '{12345, -23456, 3456, 1, -1, 0, 1'b0, 0, 0, 0},
    '{0, 0, 0, 32767, 32767, 32767, 1'b0, 0, 0, 0},
    '{0, 0, 0, 32767, 32767, 32767, 1'b0, 0, 0, 0},
    '{100, -100, -32768, -32768, -32768, -32768, 1'b0, 0, 0, 0},
    '{-32768, 32767, 32767, -1, 1, -1, 1'b0, 0, 0, 0},
    '{32767, 0, -32768, 0, 0, 0, 1'b0, 0, 0, 0},
    '{-21846, 21845, -1, 0, 0, 0, 1'b0, 0, 0, 0},
    '{32767, 32767, 32767, 32767, 32767, 32767, 1'b0, 0, 0, 0},
    '{-32768, -32768, -32768, -32768, -32768, -32768, 1'b0, 0, 0, 0},
    '{0, 0, 0, 0, 0, 0, 1'b0, 0, 0, 0},
    '{1, 1, 1, 1, 1, 1, 1'b0, 0, 0, 0},
    '{-1, -1, -1, -1, -1, -1, 1'b0, 0, 0, 0},
    '{0, 32767, -32768, 21845, -21846, 0, 1'b0, 0, 0, 0}
  };

  imu_tilt_fusion #(.CORDIC_STEPS(CordicSteps)) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_accel_x     (in_accel_x),
    .in_accel_y     (in_accel_y),
    .in_accel_z     (in_accel_z),
    .in_gyro_x      (in_gyro_x),
    .in_gyro_y      (in_gyro_y),
    .in_gyro_z      (in_gyro_z),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_roll_angle (out_roll_angle),
    .out_pitch_angle(out_pitch_angle),
    .out_yaw_angle  (out_yaw_angle),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  always #2 clk = ~clk;

  function automatic longint clamp_q16(longint v);
    if (v > QMax) return QMax;
    if (v < QMin) return QMin;
    return v;
  endfunction

  function automatic longint round_q16(longint v);
    return (v + 64'sd32768) >>> 16;
  endfunction

  function automatic longint tilt_atan2(longint num, longint den);
    longint x, y, z, xs, ys;
    int n;
    x = den;
    y = num;
    z = 0;
    n = (CordicSteps > 24) ? 24 : CordicSteps;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? HalfTurn : -HalfTurn;
      x = -x;
      y = -y;
    end
    if (y == 0) return z;
    x = x * 65536;
    y = y * 65536;
    for (int i = 0; i < n; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys;
        y = y - xs;
        z = z + step_angle[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - step_angle[i];
      end
    end
    return z;
  endfunction

  function automatic longint blend_angle(longint ang, longint integ);
    return clamp_q16(round_q16(weight_r * ang + (64'sd65536 - weight_r) * integ));
  endfunction

  task automatic advance_filter(input imu_sample_t s, output attitude_t res);
    longint gx, gy, gz;
    gx = round_q16(longint'(s.gx) * gyro_scale_r);
    gy = round_q16(longint'(s.gy) * gyro_scale_r);
    gz = round_q16(longint'(s.gz) * gyro_scale_r);
    roll_sum  = clamp_q16(roll_sum + gy);
    pitch_sum = clamp_q16(pitch_sum + gx);
    res.roll  = 32'(blend_angle(tilt_atan2(longint'(s.ay), longint'(s.az)), roll_sum));
    res.pitch = 32'(blend_angle(tilt_atan2(longint'(s.ax), longint'(s.az)), pitch_sum));
    yaw_sum   = clamp_q16(yaw_sum + yaw_gain_r * gz + yaw_bias_r);
    res.yaw   = 32'(yaw_sum);
  endtask

  task automatic write_reg(input logic [itf_pkg::CfgIdxW-1:0] idx,
                           input logic [itf_pkg::CfgW-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      itf_pkg::CFG_ACCEL_WEIGHT: weight_r     = longint'(data[16:0]);
      itf_pkg::CFG_GYRO_SCALE:   gyro_scale_r = longint'(data);
      itf_pkg::CFG_YAW_GAIN:     yaw_gain_r   = longint'(data[7:0]);
      itf_pkg::CFG_YAW_BIAS:     yaw_bias_r   = longint'($signed(data[15:0]));
      default: ;
    endcase
  endtask

  // upper bits beyond each register's width are junk and must be dropped
  task automatic apply_settings(input int w, input int sc, input int g, input int b);
    write_reg(itf_pkg::CFG_ACCEL_WEIGHT, {7'($urandom), 17'(w)});
    write_reg(itf_pkg::CFG_GYRO_SCALE, 24'(sc));
    write_reg(itf_pkg::CFG_YAW_GAIN, {16'($urandom), 8'(g)});
    write_reg(itf_pkg::CFG_YAW_BIAS, {8'($urandom), 16'(b)});
    cfg_wr_en <= 1'b0;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_angles.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic send_beat(input imu_sample_t s, input bit known, input attitude_t given);
    attitude_t calc;
    in_valid   <= 1'b1;
    in_accel_x <= s.ax;
    in_accel_y <= s.ay;
    in_accel_z <= s.az;
    in_gyro_x  <= s.gx;
    in_gyro_y  <= s.gy;
    in_gyro_z  <= s.gz;
    do @(posedge clk); while (in_stall);
    advance_filter(s, calc);
    pending_angles.push_back(known ? given : calc);
    if (!calm && $urandom_range(0, 2) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  function automatic logic signed [15:0] drift_count(int dir);
    int mag;
    mag = $urandom_range(30000, 32767);
    if (dir == 0) return 16'($urandom);
    return (dir > 0) ? 16'(mag) : -16'(mag);
  endfunction

  function automatic imu_sample_t random_sample(int dir);
    imu_sample_t s;
    int d;
    d = ($urandom_range(0, 15) == 0) ? 0 : dir;
    s.ax = 16'($urandom);
    s.ay = 16'($urandom);
    s.az = 16'($urandom);
    case ($urandom_range(0, 11))
      0: s.az = '0;
      1: s.ay = '0;
      2: s.ax = '0;
      3: begin
        s.ax = '0;
        s.ay = '0;
      end
      4: begin
        s.ax = '0;
        s.ay = '0;
        s.az = '0;
      end
      default: ;
    endcase
    s.gx = drift_count(d);
    s.gy = drift_count(d);
    s.gz = drift_count(d);
    return s;
  endfunction

  task automatic compare_angle(input string name, input logic signed [31:0] want,
                               input logic signed [31:0] got);
    if (got !== want) begin
      $display("%0t %s: expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_angles.size() == 0) begin
        $display("%0t stray beat: expected none, actual roll %0d pitch %0d yaw %0d",
                 $time, out_roll_angle, out_pitch_angle, out_yaw_angle);
        mismatches++;
      end else begin
        head_angles = pending_angles.pop_front();
        compare_angle("roll_angle", head_angles.roll, out_roll_angle);
        compare_angle("pitch_angle", head_angles.pitch, out_pitch_angle);
        compare_angle("yaw_angle", head_angles.yaw, out_yaw_angle);
      end
    end
  end

  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(10, 80)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    imu_sample_t s;
    attitude_t   given;
    int          dir;
    int          run;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_accel_x = '0;
    in_accel_y = '0;
    in_accel_z = '0;
    in_gyro_x  = '0;
    in_gyro_y  = '0;
    in_gyro_z  = '0;
    cfg_wr_en  = 1'b0;
    cfg_index  = '0;
    cfg_wdata  = '0;
    weight_r     = 62259;
    gyro_scale_r = 374806;
    yaw_gain_r   = 20;
    yaw_bias_r   = 1029;
    roll_sum     = 0;
    pitch_sum    = 0;
    yaw_sum      = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DirRows; i++) begin
      if (i == 12) begin
        settle();
        apply_settings(131071, 16777215, 255, -32768);
      end else if (i == 18) begin
        settle();
        apply_settings(0, 0, 0, 32767);
      end
      s.ax = 16'(dir_rows[i].ax);
      s.ay = 16'(dir_rows[i].ay);
      s.az = 16'(dir_rows[i].az);
      s.gx = 16'(dir_rows[i].gx);
      s.gy = 16'(dir_rows[i].gy);
      s.gz = 16'(dir_rows[i].gz);
      given.roll  = 32'(dir_rows[i].roll);
      given.pitch = 32'(dir_rows[i].pitch);
      given.yaw   = 32'(dir_rows[i].yaw);
      send_beat(s, dir_rows[i].known, given);
    end

    // a random phase, then drive the integrals into both rails, hold them, and let random rates pull them back
    for (int ph = 0; ph < 5; ph++) begin
      settle();
      dir = 0;
      run = 100;
      case (ph)
        1: begin
          apply_settings(131071, 16777215, 255, 32767);
          dir = 1;
          run = 350;
        end
        2: begin
          apply_settings(0, 16777215, 255, -32768);
          dir = -1;
          run = 620;
        end
        3: apply_settings(65536, 0, 0, 0);
        default: apply_settings($urandom_range(0, 131071), $urandom_range(0, 16777215),
                                $urandom_range(0, 255), $urandom_range(0, 65535) - 32768);
      endcase
      for (int k = 0; k < run; k++) begin
        if (ph == 4 && k == 40) calm = 1'b1;
        given = '0;
        send_beat(random_sample(dir), 1'b0, given);
      end
    end

    settle();
    repeat (2 * CordicSteps + 19) @(posedge clk);
    if (mismatches == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
